// ===== src/gda_pkg.sv =====
// Package for the Gregorian date arithmetic block: field widths, opcodes,
// sequencer states and the calendar helper functions. No dependencies.
package gda_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned StepW  = 12;
  localparam int unsigned CountW = 9;
  localparam int unsigned AccW   = 14;  // signed running day count

  localparam logic [YearW-1:0] YearMin = YearW'(1);
  localparam logic [YearW-1:0] YearMax = YearW'(9999);

  localparam logic [OpW-1:0] OpNextDay = 3'd0;
  localparam logic [OpW-1:0] OpPrevDay = 3'd1;
  localparam logic [OpW-1:0] OpAddDays = 3'd2;
  localparam logic [OpW-1:0] OpSubDays = 3'd3;
  localparam logic [OpW-1:0] OpDayOfYr = 3'd4;
  localparam logic [OpW-1:0] OpWeekday = 3'd5;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_FWD   = 8'b0000_0100,
    S_BWD   = 8'b0000_1000,
    S_DOY   = 8'b0001_0000,
    S_WSUM  = 8'b0010_0000,
    S_WMOD  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // Quotient by 100 through a reciprocal; exact for every 14-bit value.
  function automatic logic [7:0] div100(input logic [YearW-1:0] y);
    logic [26:0] p;
    p = 27'(y) * 27'd5243;
    return p[26:19];
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [7:0]       q;
    logic [YearW-1:0] r;
    q = div100(y);
    r = y - YearW'(q) * YearW'(100);
    return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd2:                              len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:           len = 5'd30;
      [4'd1:4'd12]:                      len = 5'd31;
      default:                           len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== src/gda_if.sv =====
// Request and response channel interfaces of the date arithmetic block.
// Depends on gda_pkg for the field widths.
interface gda_req_if import gda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [DayW-1:0]   in_day;
  logic [MonW-1:0]   in_month;
  logic [YearW-1:0]  in_year;
  logic [StepW-1:0]  step_days;

  modport source (output valid, opcode, in_day, in_month, in_year, step_days,
                  input ready);
  modport sink   (input valid, opcode, in_day, in_month, in_year, step_days,
                  output ready);
endinterface

interface gda_rsp_if import gda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   out_day;
  logic [MonW-1:0]   out_month;
  logic [YearW-1:0]  out_year;
  logic [CountW-1:0] count;
  logic              valid_res;

  modport source (output valid, out_day, out_month, out_year, count, valid_res,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, count, valid_res,
                  output ready);
endinterface

// ===== src/gregorian_date_arithmetic.sv =====
// Top level of the Gregorian date arithmetic block: a small sequencer around
// one shared month-length lookup and day-count adder. Uses gda_pkg, gda_if.
//
//   channel | dir | fields
//   req_i   | in  | opcode, in_day, in_month, in_year, step_days
//   rsp_o   | out | out_day, out_month, out_year, count, valid_res
//
// One transaction is handled at a time; req_i.ready is high only when idle.
// The time a transaction takes grows with the months that its walk passes
// through the shared adder; next and previous day walk at most one month.
// Reset clears the sequencer and the response valid; no memory to clear.
// A finished result waits in the response register while rsp_o is stalled;
// the sequencer holds in its output state until that register is free.
module gregorian_date_arithmetic
  import gda_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gda_req_if.sink    req_i,
  gda_rsp_if.source  rsp_o
);

  // Captured request.
  logic [OpW-1:0]   op_q;
  logic [DayW-1:0]  d0_q;
  logic [MonW-1:0]  m0_q;
  logic [YearW-1:0] y0_q;
  logic [StepW-1:0] k_q;

  // Working registers of the month walk.
  state_e                  state_q, state_d;
  logic signed [AccW-1:0]  d_q, d_d;
  logic [MonW-1:0]         m_q, m_d;
  logic [YearW-1:0]        y_q, y_d;
  logic                    ok_q, ok_d;
  logic [CountW-1:0]       cnt_q, cnt_d;
  logic [YearW-1:0]        wsum_q, wsum_d;

  // Response register.
  logic              out_valid_q;
  logic [DayW-1:0]   out_day_q;
  logic [MonW-1:0]   out_month_q;
  logic [YearW-1:0]  out_year_q;
  logic [CountW-1:0] out_count_q;
  logic              out_ok_q;

  logic req_fire, rsp_fire, out_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = out_valid_q && rsp_o.ready;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || rsp_o.ready);

  // Shared month-length unit. Walking backwards it looks at the month before
  // the current one, wrapping into December of the previous year.
  logic                   walk_back;
  logic [MonW-1:0]        m_prev, lu_m;
  logic [YearW-1:0]       y_prev, lu_y;
  logic [DayW-1:0]        ml;
  logic signed [AccW-1:0] ml_ext, acc_sum;

  assign walk_back = (state_q == S_BWD);
  assign m_prev    = (m_q == 4'd1) ? 4'd12 : m_q - 4'd1;
  assign y_prev    = (m_q == 4'd1) ? y_q - YearW'(1) : y_q;
  assign lu_m      = walk_back ? m_prev : m_q;
  assign lu_y      = walk_back ? y_prev : y_q;
  assign ml        = month_len(lu_m, is_leap(lu_y));
  assign ml_ext    = $signed({{(AccW-DayW){1'b0}}, ml});

  // Shared adder: the forward walk subtracts a month, all others add one.
  assign acc_sum = (state_q == S_FWD) ? d_q - ml_ext : d_q + ml_ext;

  // Input date check and start value of the running day count.
  logic                   date_ok;
  logic signed [AccW-1:0] d0_ext, k_ext;

  assign date_ok = (y_q >= YearMin) && (y_q <= YearMax) && (ml != '0) &&
                   (d0_q != '0) && (d0_q <= ml);
  assign d0_ext  = $signed({{(AccW-DayW){1'b0}}, d0_q});
  assign k_ext   = $signed({{(AccW-StepW){1'b0}}, k_q});

  // Weekday: 365 is 1 mod 7, so the day number since 0001-01-01 reduces to
  // yb + yb/4 - yb/100 + yb/400 + doy - 1 before the mod 7.
  logic [YearW-1:0] yb;
  logic [7:0]       yb_c;
  logic [YearW:0]   wsum_full;
  logic [27:0]      w_prod;
  logic [11:0]      w_quo;
  logic [YearW-1:0] w_rem_full;
  logic [3:0]       w_rem;
  logic [2:0]       w_day;

  assign yb        = y0_q - YearW'(1);
  assign yb_c      = div100(yb);
  assign wsum_full = (YearW+1)'(yb) + (YearW+1)'(yb >> 2) - (YearW+1)'(yb_c)
                   + (YearW+1)'(yb_c >> 2) + (YearW+1)'(d_q[CountW-1:0])
                   - (YearW+1)'(1);
  // The reciprocal rounds down, so the quotient is exact or one short.
  assign w_prod     = 28'(wsum_q) * 28'd9362;
  assign w_quo      = w_prod[27:16];
  assign w_rem_full = wsum_q - YearW'(w_quo) * YearW'(7);
  assign w_rem      = w_rem_full[3:0];
  assign w_day      = (w_rem >= 4'd7) ? 3'(w_rem - 4'd7) : w_rem[2:0];

  always_comb begin
    state_d = state_q;
    d_d     = d_q;
    m_d     = m_q;
    y_d     = y_q;
    ok_d    = ok_q;
    cnt_d   = cnt_q;
    wsum_d  = wsum_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          m_d     = req_i.in_month;
          y_d     = req_i.in_year;
          ok_d    = 1'b1;
          cnt_d   = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!date_ok) begin
          ok_d    = 1'b0;
          state_d = S_OUT;
        end else begin
          case (op_q)
            OpNextDay: begin
              d_d     = d0_ext + AccW'(1);
              state_d = S_FWD;
            end
            OpAddDays: begin
              d_d     = d0_ext + k_ext;
              state_d = S_FWD;
            end
            OpPrevDay: begin
              d_d     = d0_ext - AccW'(1);
              state_d = S_BWD;
            end
            OpSubDays: begin
              d_d     = d0_ext - k_ext;
              state_d = S_BWD;
            end
            OpDayOfYr, OpWeekday: begin
              d_d     = d0_ext;
              m_d     = 4'd1;
              state_d = S_DOY;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_FWD: begin
        if (d_q > ml_ext) begin
          d_d = acc_sum;
          if (m_q == 4'd12) begin
            m_d = 4'd1;
            y_d = y_q + YearW'(1);
            if (y_q >= YearMax) begin
              ok_d    = 1'b0;
              state_d = S_OUT;
            end
          end else begin
            m_d = m_q + 4'd1;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_BWD: begin
        if (d_q < AccW'(1)) begin
          if (y_prev < YearMin) begin
            ok_d    = 1'b0;
            state_d = S_OUT;
          end else begin
            d_d = acc_sum;
            m_d = m_prev;
            y_d = y_prev;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_DOY: begin
        if (m_q < m0_q) begin
          d_d = acc_sum;
          m_d = m_q + 4'd1;
        end else if (op_q == OpDayOfYr) begin
          // The running count held the day of year; the result date echoes
          // the input day, so it goes back into the day register.
          cnt_d   = d_q[CountW-1:0];
          d_d     = d0_ext;
          state_d = S_OUT;
        end else begin
          state_d = S_WSUM;
        end
      end
      S_WSUM: begin
        wsum_d  = wsum_full[YearW-1:0];
        d_d     = d0_ext;
        state_d = S_WMOD;
      end
      S_WMOD: begin
        cnt_d   = CountW'(w_day);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q <= req_i.opcode;
      d0_q <= req_i.in_day;
      m0_q <= req_i.in_month;
      y0_q <= req_i.in_year;
      k_q  <= req_i.step_days;
    end
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    ok_q   <= ok_d;
    cnt_q  <= cnt_d;
    wsum_q <= wsum_d;
    // A failed transaction echoes the input date with a zero count.
    if (out_load) begin
      out_ok_q    <= ok_q;
      out_day_q   <= ok_q ? d_q[DayW-1:0] : d0_q;
      out_month_q <= ok_q ? m_q : m0_q;
      out_year_q  <= ok_q ? y_q : y0_q;
      out_count_q <= ok_q ? cnt_q : '0;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_day   = out_day_q;
  assign rsp_o.out_month = out_month_q;
  assign rsp_o.out_year  = out_year_q;
  assign rsp_o.count     = out_count_q;
  assign rsp_o.valid_res = out_ok_q;

`ifndef SYNTHESIS
  // A request is only taken when the sequencer is free, and it starts a check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_CHECK))
    else $error("request accepted but sequencer did not start");

  // A good result never carries a year outside the calendar range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> (out_year_q >= YearMin && out_year_q <= YearMax))
    else $error("valid result with year out of range");

  // A failed result reports a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_count_q == '0))
    else $error("failed result with nonzero count");

  // The response register is loaded only from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("response raised outside the output state");
`endif

endmodule

// ===== verif/gregorian_date_arithmetic_test.sv =====
// Self-checking regression for the Gregorian date arithmetic block.
// Depends on gda_pkg, gda_req_if, gda_rsp_if and gregorian_date_arithmetic.
`timescale 1ns / 100ps

module gregorian_date_arithmetic_test;
  import gda_pkg::*;

  // The package names only the six defined operations; these two fill out the
  // opcode field and must be answered as invalid.
  localparam logic [OpW-1:0] OpUnusedLo = 3'd6;
  localparam logic [OpW-1:0] OpUnusedHi = 3'd7;

  localparam int unsigned DirectedMax = 32;
  localparam int unsigned RandomItems = 1825;
  localparam int unsigned DrainPause  = 900;   // sender waits for an empty pipe here
  localparam int unsigned LongHoldAt  = 300;   // response index of the long receiver hold
  localparam int unsigned LongHoldLen = 400;
  localparam int unsigned TailCycles  = 200;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [DayW-1:0]  in_day;
    logic [MonW-1:0]  in_month;
    logic [YearW-1:0] in_year;
    logic [StepW-1:0] step_days;
  } date_req_t;

  typedef struct packed {
    logic [DayW-1:0]   out_day;
    logic [MonW-1:0]   out_month;
    logic [YearW-1:0]  out_year;
    logic [CountW-1:0] count;
    logic              valid_res;
  } date_rsp_t;

  // Calendar arithmetic of the testbench, kept apart from the package helpers.
  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int m, int y);
    int len;
    if (m < 1 || m > 12) begin
      len = 0;
    end else if (m == 2) begin
      len = leap_year(y) ? 29 : 28;
    end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
      len = 30;
    end else begin
      len = 31;
    end
    return len;
  endfunction

  function automatic int ordinal_day(int d, int m, int y);
    int total;
    total = d;
    for (int i = 1; i < m && i <= 12; i++) begin
      total += days_in_month(i, y);
    end
    return total;
  endfunction

  // The scoreboard works out the answer for each accepted request and keeps
  // it until the matching response transaction arrives. Responses come back
  // in request order, so a plain FIFO is enough.
  class date_scoreboard;
    date_rsp_t expected_dates[$];
    int        failures;

    function new();
      failures = 0;
    endfunction

    function date_rsp_t date_outcome(date_req_t r);
      date_rsp_t res;
      int        d, m, y, k, cnt, yb, dn;
      bit        ok;
      d   = int'(r.in_day);
      m   = int'(r.in_month);
      y   = int'(r.in_year);
      k   = int'(r.step_days);
      cnt = 0;
      ok  = (y >= 1) && (y <= 9999) && (m >= 1) && (m <= 12) &&
            (d >= 1) && (d <= days_in_month(m, y));
      if (ok) begin
        case (r.opcode)
          OpNextDay, OpAddDays: begin
            d += (r.opcode == OpNextDay) ? 1 : k;
            // Walk forward one month at a time; running past 9999 is out of range.
            while (d > days_in_month(m, y)) begin
              d -= days_in_month(m, y);
              m++;
              if (m > 12) begin
                m = 1;
                y++;
                if (y > 9999) begin
                  ok = 1'b0;
                  break;
                end
              end
            end
          end
          OpPrevDay, OpSubDays: begin
            d -= (r.opcode == OpPrevDay) ? 1 : k;
            while (d < 1) begin
              m--;
              if (m < 1) begin
                m = 12;
                y--;
                if (y < 1) begin
                  ok = 1'b0;
                  break;
                end
              end
              d += days_in_month(m, y);
            end
          end
          OpDayOfYr: begin
            cnt = ordinal_day(d, m, y);
          end
          OpWeekday: begin
            // Day count since 0001-01-01, a Monday; never negative.
            yb  = y - 1;
            dn  = 365 * yb + yb / 4 - yb / 100 + yb / 400 + ordinal_day(d, m, y) - 1;
            cnt = dn % 7;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      if (!ok) begin
        d   = int'(r.in_day);
        m   = int'(r.in_month);
        y   = int'(r.in_year);
        cnt = 0;
      end
      res.out_day   = DayW'(d);
      res.out_month = MonW'(m);
      res.out_year  = YearW'(y);
      res.count     = CountW'(cnt);
      res.valid_res = ok;
      return res;
    endfunction

    function void note_request(date_req_t r);
      expected_dates.push_back(date_outcome(r));
    endfunction

    function void check_response(date_rsp_t got);
      date_rsp_t exp;
      if (expected_dates.size() == 0) begin
        $error("response with no request outstanding: day %0d month %0d year %0d",
               got.out_day, got.out_month, got.out_year);
        failures++;
        return;
      end
      exp = expected_dates.pop_front();
      if (got.out_day !== exp.out_day) begin
        $error("out_day expected %0d actual %0d", exp.out_day, got.out_day);
        failures++;
      end
      if (got.out_month !== exp.out_month) begin
        $error("out_month expected %0d actual %0d", exp.out_month, got.out_month);
        failures++;
      end
      if (got.out_year !== exp.out_year) begin
        $error("out_year expected %0d actual %0d", exp.out_year, got.out_year);
        failures++;
      end
      if (got.count !== exp.count) begin
        $error("count expected %0d actual %0d", exp.count, got.count);
        failures++;
      end
      if (got.valid_res !== exp.valid_res) begin
        $error("valid_res expected %0d actual %0d", exp.valid_res, got.valid_res);
        failures++;
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  gda_req_if req_bus ();
  gda_rsp_if rsp_bus ();

  gregorian_date_arithmetic dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  date_scoreboard sb;
  date_req_t      directed_dates[DirectedMax];
  int unsigned    directed_count;
  bit             sender_steady;    // when set, the sender offers back to back
  bit             receiver_steady;  // when set, the receiver stalls only for the long hold

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every block input is known from time zero; the reset is the only one of the run.
  initial begin
    rst_ni            <= 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.opcode    <= '0;
    req_bus.in_day    <= '0;
    req_bus.in_month  <= '0;
    req_bus.in_year   <= '0;
    req_bus.step_days <= '0;
    rsp_bus.ready     <= 1'b0;
  end

  function automatic date_req_t make_req(logic [OpW-1:0] op, int d, int m, int y, int k);
    date_req_t r;
    r.opcode    = op;
    r.in_day    = DayW'(d);
    r.in_month  = MonW'(m);
    r.in_year   = YearW'(y);
    r.step_days = StepW'(k);
    return r;
  endfunction

  // Random requests. Most are well-formed dates with random content, biased
  // toward month ends, century years and the two ends of the year range so
  // that month walks cross February and the range limits often. The rest is
  // raw noise over the field ranges, years up to 9999, including the unused opcodes.
  function automatic date_req_t random_request();
    date_req_t r;
    int        y, m, d, k, dim;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      r.opcode    = OpW'($urandom_range(7, 0));
      r.in_day    = DayW'($urandom_range(31, 0));
      r.in_month  = MonW'($urandom_range(15, 0));
      r.in_year   = YearW'($urandom_range(9999, 0));
      r.step_days = StepW'($urandom_range(4095, 0));
      return r;
    end
    case ($urandom_range(9, 0))
      0:       y = $urandom_range(3, 1);
      1:       y = $urandom_range(9999, 9996);
      2:       y = 100 * $urandom_range(99, 1) + $urandom_range(1, 0);
      3:       y = 4 * $urandom_range(2499, 1);
      default: y = $urandom_range(9999, 1);
    endcase
    m   = $urandom_range(12, 1);
    dim = days_in_month(m, y);
    if ($urandom_range(9, 0) < 3) begin
      d = dim - $urandom_range(1, 0);
    end else begin
      d = $urandom_range(dim, 1);
    end
    case ($urandom_range(9, 0))
      0, 1, 2: k = $urandom_range(40, 0);
      3, 4:    k = $urandom_range(400, 0);
      5:       k = $urandom_range(4095, 4000);
      default: k = $urandom_range(4095, 0);
    endcase
    r = make_req(OpW'($urandom_range(OpWeekday, OpNextDay)), d, m, y, k);
    return r;
  endfunction

  // Offers one request and returns at the edge where it was accepted. Valid
  // stays high on return, so a back-to-back request never drops it.
  task automatic send_request(date_req_t r);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.opcode    <= r.opcode;
    req_bus.in_day    <= r.in_day;
    req_bus.in_month  <= r.in_month;
    req_bus.in_year   <= r.in_year;
    req_bus.step_days <= r.step_days;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(r);
  endtask

  // Response side: a stall of random length, possibly none, before each
  // transaction, stretches without stalls, and one long hold so the block backs
  // up into its request port while the sender keeps offering.
  task automatic collect_responses();
    date_rsp_t   got;
    int unsigned stall;
    int unsigned seen;
    seen = 0;
    forever begin
      if (seen % 50 == 0) begin
        receiver_steady = ($urandom_range(3, 0) == 0);
      end
      stall = receiver_steady ? 0 : $urandom_range(6, 0);
      if (seen == LongHoldAt) begin
        stall = LongHoldLen;
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_bus.valid);
      got.out_day   = rsp_bus.out_day;
      got.out_month = rsp_bus.out_month;
      got.out_year  = rsp_bus.out_year;
      got.count     = rsp_bus.count;
      got.valid_res = rsp_bus.valid_res;
      sb.check_response(got);
      seen++;
    end
  endtask

  task automatic load_directed();
    int unsigned n;
    n = 0;
    // Range limits of next and previous day.
    directed_dates[n++] = make_req(OpNextDay, 31, 12, 9999, 0);
    directed_dates[n++] = make_req(OpPrevDay, 1, 1, 1, 4095);
    // February in leap and non-leap century years, and the end of January.
    directed_dates[n++] = make_req(OpNextDay, 28, 2, 2000, 0);
    directed_dates[n++] = make_req(OpNextDay, 28, 2, 1900, 0);
    directed_dates[n++] = make_req(OpPrevDay, 1, 3, 2000, 0);
    directed_dates[n++] = make_req(OpNextDay, 31, 1, 2023, 0);
    // Largest steps, leaving the year range and staying inside it, and zero steps.
    directed_dates[n++] = make_req(OpAddDays, 15, 10, 9988, 4095);
    directed_dates[n++] = make_req(OpAddDays, 1, 1, 1, 4095);
    directed_dates[n++] = make_req(OpSubDays, 1, 3, 12, 4095);
    directed_dates[n++] = make_req(OpSubDays, 31, 12, 9999, 4095);
    directed_dates[n++] = make_req(OpAddDays, 31, 1, 2024, 0);
    directed_dates[n++] = make_req(OpSubDays, 31, 1, 2024, 0);
    // A walk that passes February of a leap year from a January start.
    directed_dates[n++] = make_req(OpAddDays, 30, 1, 2023, 400);
    // Day of year and weekday, with a step count that must be ignored.
    directed_dates[n++] = make_req(OpDayOfYr, 31, 12, 2024, 4095);
    directed_dates[n++] = make_req(OpDayOfYr, 31, 12, 2023, 0);
    directed_dates[n++] = make_req(OpWeekday, 1, 1, 1970, 0);
    directed_dates[n++] = make_req(OpWeekday, 1, 1, 1, 4095);
    directed_dates[n++] = make_req(OpWeekday, 31, 12, 9999, 0);
    directed_dates[n++] = make_req(OpWeekday, 29, 2, 2000, 0);
    // Invalid input dates: leap day of a common century, zero and overlong
    // days, months out of range at both field ends, year zero.
    directed_dates[n++] = make_req(OpNextDay, 29, 2, 1900, 0);
    directed_dates[n++] = make_req(OpAddDays, 0, 6, 2020, 10);
    directed_dates[n++] = make_req(OpDayOfYr, 31, 4, 2021, 0);
    directed_dates[n++] = make_req(OpWeekday, 15, 0, 2021, 0);
    directed_dates[n++] = make_req(OpPrevDay, 31, 15, 2021, 0);
    directed_dates[n++] = make_req(OpSubDays, 10, 5, 0, 5);
    // Opcodes with no operation behind them.
    directed_dates[n++] = make_req(OpUnusedLo, 10, 5, 2000, 7);
    directed_dates[n++] = make_req(OpUnusedHi, 31, 12, 9999, 4095);
    directed_count = n;
  endtask

  initial begin
    sb              = new();
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    load_directed();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      collect_responses();
    join_none

    for (int unsigned i = 0; i < directed_count; i++) begin
      send_request(directed_dates[i]);
    end

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) begin
        sender_steady = ($urandom_range(3, 0) == 0);
      end
      // Once in the run the sender stops until the pipe has drained, so a
      // request also meets a fully idle block.
      if (i == DrainPause) begin
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_request(random_request());
    end
    req_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    // Any stray response after the last expected one is still caught here.
    repeat (TailCycles) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("gregorian_date_arithmetic regression: pass");
    end else begin
      $display("gregorian_date_arithmetic regression: fail");
    end
    $finish;
  end

  // A correct run takes well under a third of this.
  initial begin
    #30_000_000;
    $display("gregorian_date_arithmetic regression: fail");
    $finish;
  end

endmodule
